>>> design/tcp_flow_accounting_table_macros.svh
// Assertion macros for the flow accounting table checker.
`ifndef TCP_FLOW_ACCOUNTING_TABLE_MACROS_SVH
`define TCP_FLOW_ACCOUNTING_TABLE_MACROS_SVH
// clocked implication, reset masked
`define FAT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("flow table check failed");
// implication into the next cycle
`define FAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("flow table check failed");
`endif

>>> design/fat_pkg.sv
// Shared types and constants of the flow accounting table.
package fat_pkg;
  localparam int FLOW_ENTRIES = 1024;
  localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);

  localparam logic [1:0] REQ_STATE = 2'd0;
  localparam logic [1:0] REQ_SENT  = 2'd1;
  localparam logic [1:0] REQ_RECV  = 2'd2;

  localparam logic [15:0] FAM_IPV4  = 16'd2;
  localparam logic [7:0]  PROTO_TCP = 8'd6;

  localparam logic [3:0] TCP_STATE_EST   = 4'd1;
  localparam logic [3:0] TCP_FIN_WAIT1   = 4'd4;
  localparam logic [3:0] TCP_TIME_WAIT   = 4'd6;
  localparam logic [3:0] TCP_CLOSE       = 4'd7;
  localparam logic [3:0] TCP_LAST_ACK    = 4'd9;

  localparam logic EV_OPEN  = 1'b0;
  localparam logic EV_CLOSE = 1'b1;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] sent;
    logic [63:0] recv;
    logic        open_m;
    logic        closed_m;
  } ent_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DECIDE
  } state_e;
endpackage

>>> design/tcp_flow_accounting_table.sv
// Flow table top: linear key search, read-modify-write and event output.
// Search: a read and a compare state per stored flow searched, then decide; the result strobe is registered.
// A new item is accepted only while idle (busy low); the single memory read port sets the pace.
// busy is high after accept through the decide state; valid_o pulses one cycle.
// Reset (asynchronous, rst_ni low) empties the table via the fill count.
module tcp_flow_accounting_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] flow_key_i,
  input  logic [15:0] addr_family_i,
  input  logic [7:0]  proto_num_i,
  input  logic [3:0]  new_state_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  input  logic [15:0] src_port_i,
  input  logic [15:0] dst_port_i,
  input  logic [31:0] process_id_i,
  input  logic [31:0] netns_id_i,
  input  logic signed [32:0] byte_count_i,
  output logic        valid_o,
  output logic        event_kind_o,
  output logic [31:0] ev_netns_o,
  output logic [31:0] ev_src_addr_o,
  output logic [31:0] ev_dst_addr_o,
  output logic [15:0] ev_src_port_o,
  output logic [15:0] ev_dst_port_o,
  output logic [7:0]  ev_proto_o,
  output logic [31:0] ev_pid_o,
  output logic [63:0] sent_total_o,
  output logic [63:0] recv_total_o
);
  fat_pkg::state_e state_q, state_d;
  logic [fat_pkg::CNT_W-1:0] fill_q, fill_d;
  logic [fat_pkg::IDX_W-1:0] idx_q, idx_d;
  logic found_q, found_d;

  logic [1:0]  req_q;
  logic [63:0] key_q;
  logic [15:0] fam_q;
  logic [7:0]  proto_q;
  logic [3:0]  st_q;
  logic [31:0] saddr_q, daddr_q, pid_q, ns_q;
  logic [15:0] sport_q, dport_q;
  logic [32:0] cnt_q;

  logic accept;
  logic we, re;
  logic [fat_pkg::IDX_W-1:0] waddr;
  fat_pkg::ent_t wdata, rdata, cur;
  logic emit, kind;
  logic [63:0] sum_a, sum;
  logic [63:0] out_sent, out_recv;
  logic is_close, full;

  assign accept = start && !busy;
  assign busy   = (state_q != fat_pkg::ST_IDLE);

  fat_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= req_type_i;
      key_q   <= flow_key_i;
      fam_q   <= addr_family_i;
      proto_q <= proto_num_i;
      st_q    <= new_state_i;
      saddr_q <= src_addr_i;
      daddr_q <= dst_addr_i;
      sport_q <= src_port_i;
      dport_q <= dst_port_i;
      pid_q   <= process_id_i;
      ns_q    <= netns_id_i;
      cnt_q   <= byte_count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fat_pkg::ST_IDLE;
      fill_q  <= '0;
      idx_q   <= '0;
      found_q <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      idx_q   <= idx_d;
      found_q <= found_d;
      valid_o <= emit;
    end
  end

  // shared 64-bit adder for the counter update
  assign cur   = found_q ? rdata : '0;
  assign sum_a = (req_q == fat_pkg::REQ_SENT) ? cur.sent : cur.recv;
  assign sum   = sum_a + {{31{cnt_q[32]}}, cnt_q};
  assign full  = (fill_q == fat_pkg::CNT_W'(fat_pkg::FLOW_ENTRIES));
  assign is_close = (st_q == fat_pkg::TCP_FIN_WAIT1) || (st_q == fat_pkg::TCP_TIME_WAIT) ||
                    (st_q == fat_pkg::TCP_CLOSE) || (st_q == fat_pkg::TCP_LAST_ACK);

  always_comb begin
    logic store;
    state_d  = state_q;
    fill_d   = fill_q;
    idx_d    = idx_q;
    found_d  = found_q;
    re       = 1'b0;
    we       = 1'b0;
    store    = 1'b0;
    waddr    = found_q ? idx_q : fill_q[fat_pkg::IDX_W-1:0];
    wdata    = cur;
    wdata.key = key_q;
    emit     = 1'b0;
    kind     = fat_pkg::EV_OPEN;
    out_sent = '0;
    out_recv = '0;
    case (state_q)
      fat_pkg::ST_IDLE: begin
        if (accept) begin
          idx_d   = '0;
          found_d = 1'b0;
          state_d = (fill_q == '0) ? fat_pkg::ST_DECIDE : fat_pkg::ST_READ;
        end
      end
      fat_pkg::ST_READ: begin
        re      = 1'b1;
        state_d = fat_pkg::ST_CMP;
      end
      fat_pkg::ST_CMP: begin
        if (rdata.key == key_q) begin
          found_d = 1'b1;
          state_d = fat_pkg::ST_DECIDE;
        end else if (fat_pkg::CNT_W'(idx_q) + 1'b1 == fill_q) begin
          state_d = fat_pkg::ST_DECIDE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = fat_pkg::ST_READ;
        end
      end
      fat_pkg::ST_DECIDE: begin
        state_d = fat_pkg::ST_IDLE;
        case (req_q)
          fat_pkg::REQ_STATE: begin
            if (fam_q == fat_pkg::FAM_IPV4 && proto_q == fat_pkg::PROTO_TCP) begin
              if (st_q == fat_pkg::TCP_STATE_EST && !(found_q && cur.open_m)) begin
                emit  = 1'b1;
                kind  = fat_pkg::EV_OPEN;
                store = 1'b1;
                wdata.sent = '0;
                wdata.recv = '0;
                wdata.open_m = 1'b1;
                wdata.closed_m = 1'b0;
              end else if (is_close && !(found_q && cur.closed_m)) begin
                emit  = 1'b1;
                kind  = fat_pkg::EV_CLOSE;
                out_sent = cur.sent;
                out_recv = cur.recv;
                store = 1'b1;
                wdata.sent = '0;
                wdata.recv = '0;
                wdata.open_m = 1'b0;
                wdata.closed_m = 1'b1;
              end
            end
          end
          fat_pkg::REQ_SENT: begin
            store = 1'b1;
            wdata.sent = sum;
          end
          fat_pkg::REQ_RECV: begin
            // receive ignores counts not above zero
            if (!cnt_q[32] && cnt_q != '0) begin
              store = 1'b1;
              wdata.recv = sum;
            end
          end
          default: begin
          end
        endcase
        if (store && (found_q || !full)) begin
          we = 1'b1;
          if (!found_q) begin
            fill_d = fill_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = fat_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      event_kind_o  <= kind;
      ev_netns_o    <= ns_q;
      ev_src_addr_o <= saddr_q;
      ev_dst_addr_o <= daddr_q;
      ev_src_port_o <= sport_q;
      ev_dst_port_o <= dport_q;
      ev_proto_o    <= proto_q;
      ev_pid_o      <= pid_q;
      sent_total_o  <= out_sent;
      recv_total_o  <= out_recv;
    end
  end
endmodule

>>> design/fat_mem.sv
// Flow entry memory: one write port, one registered read port.
module fat_mem (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [fat_pkg::IDX_W-1:0] waddr_i,
  input  fat_pkg::ent_t             wdata_i,
  input  logic                      re_i,
  input  logic [fat_pkg::IDX_W-1:0] raddr_i,
  output fat_pkg::ent_t             rdata_o
);
  fat_pkg::ent_t mem_q [fat_pkg::FLOW_ENTRIES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

>>> design/fat_chk.sv
// Port-level checker for the flow accounting table, bound to the top level.
`include "tcp_flow_accounting_table_macros.svh"
module fat_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        valid_o,
  input logic        event_kind_o,
  input logic [7:0]  ev_proto_o,
  input logic [63:0] sent_total_o,
  input logic [63:0] recv_total_o
);
  `FAT_ASSERT_NEXT(a_busy_after_start, clk_i, rst_ni, start && !busy, busy)
  `FAT_ASSERT_IMP(a_result_after_work, clk_i, rst_ni, valid_o, $past(busy) && !busy)
  `FAT_ASSERT_IMP(a_tcp_only, clk_i, rst_ni, valid_o, ev_proto_o == fat_pkg::PROTO_TCP)
  `FAT_ASSERT_IMP(a_open_zero, clk_i, rst_ni, valid_o && !event_kind_o,
                  sent_total_o == 64'd0 && recv_total_o == 64'd0)
endmodule

bind tcp_flow_accounting_table fat_chk u_fat_chk (.*);
